[src/fsvt_pkg.sv]
// ----------------------------------------------------------------------------
// fsvt_pkg: shared types and constants of the frame store view transform
// Field widths, register indexes, view mode codes, controller state and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package fsvt_pkg;

   localparam int COORD_W     = 8;
   localparam int SIZE_W      = 9;
   localparam int MODE_W      = 2;
   localparam int CHAN_W      = 8;
   localparam int PIXEL_W     = 3 * CHAN_W;
   localparam int PROD_W      = COORD_W + SIZE_W;
   localparam int QUOT_W      = SIZE_W;
   localparam int STEP_W      = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = SIZE_W;

   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_VIEW_MODE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CROP_LEFT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CROP_TOP      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_VIEW_WIDTH    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_VIEW_HEIGHT   = 3'd6;

   localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CROP   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ROTATE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESIZE = 2'd3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_COL,
      ST_WAIT_COL,
      ST_DIV_ROW,
      ST_WAIT_ROW,
      ST_READ,
      ST_RESP
   } fsvt_state_type;

   typedef struct packed {
      logic load;
      logic latch_map;
      logic mem_write;
      logic div_start;
      logic div_row;
      logic latch_div_col;
      logic latch_div_row;
      logic mem_read;
   } fsvt_cmd_type;

   typedef struct packed {
      logic is_read;
      logic is_resize;
      logic wr_in_range;
      logic div_done;
   } fsvt_status_type;

endpackage

[src/frame_store_view_transform_unit.sv]
// ----------------------------------------------------------------------------
// frame_store_view_transform_unit: RGB frame store read through a view
// Stores pixels at source coordinates and reads them back direct, cropped,
// rotated clockwise or resized by nearest neighbor.
//
//   channel   ports                         transfer
//   request   start, busy, req_*            start high while busy low
//   response  rsp_valid, rsp_*              rsp_valid high, one cycle
//   config    csr_we, csr_index, csr_wdata  csr_we high
//
// A write passes through the prep state back to idle. A direct, crop or
// rotated read steps through prep, read and response states, its response
// strobed in the last one. A resized read adds two divisions on the shared
// divider, which runs one bit per cycle, 9 steps for the column and 9 for
// the row. The response cannot be held off, so an accepted item never stalls.
// Reset restores the view registers; pixel memory holds what was written.
// ----------------------------------------------------------------------------
module frame_store_view_transform_unit #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_operation,
   input  logic [fsvt_pkg::COORD_W-1:0]      req_col,
   input  logic [fsvt_pkg::COORD_W-1:0]      req_row,
   input  logic [fsvt_pkg::CHAN_W-1:0]       req_red_in,
   input  logic [fsvt_pkg::CHAN_W-1:0]       req_green_in,
   input  logic [fsvt_pkg::CHAN_W-1:0]       req_blue_in,
   output logic                              rsp_valid,
   output logic [fsvt_pkg::CHAN_W-1:0]       rsp_red_out,
   output logic [fsvt_pkg::CHAN_W-1:0]       rsp_green_out,
   output logic [fsvt_pkg::CHAN_W-1:0]       rsp_blue_out,
   input  logic                              csr_we,
   input  logic [fsvt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fsvt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fsvt_pkg::*;

   fsvt_cmd_type    cmd;
   fsvt_status_type status;

   fsvt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   fsvt_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_operation (req_operation),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .cmd           (cmd),
      .status        (status),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out)
   );

`ifndef SYNTHESIS
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe outside an item");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not occupy the unit");

   a_write_short: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == OP_WRITE)) |=> ##1 (!busy && !rsp_valid))
      else $error("write did not retire in two cycles");
`endif

endmodule

[src/fsvt_divider.sv]
// ----------------------------------------------------------------------------
// fsvt_divider: shared restoring divider
// One quotient bit per cycle; the quotient is known to fit QUOT_W bits, so
// the upper dividend bits seed the remainder and QUOT_W steps suffice.
// ----------------------------------------------------------------------------
module fsvt_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fsvt_pkg::PROD_W-1:0]   dividend,
   input  logic [fsvt_pkg::SIZE_W-1:0]   divisor,
   output logic [fsvt_pkg::QUOT_W-1:0]   quotient,
   output logic                          done
);
   import fsvt_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0] quo_ff, quo_in;
   logic [SIZE_W-1:0] divisor_ff;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SIZE_W:0]   trial;
   logic              ge;

   always_comb begin
      trial    = {rem_ff, quo_ff[QUOT_W-1]};
      ge       = trial >= {1'b0, divisor_ff};
      rem_in   = ge ? SIZE_W'(trial - {1'b0, divisor_ff}) : SIZE_W'(trial);
      quo_in   = {quo_ff[QUOT_W-2:0], ge};
      count_in = count_ff + STEP_W'(1);
      busy_in  = busy_ff && (count_ff != LAST_STEP);
      done_in  = busy_ff && (count_ff == LAST_STEP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         rem_ff     <= SIZE_W'(dividend[PROD_W-1:QUOT_W]);
         quo_ff     <= dividend[QUOT_W-1:0];
         divisor_ff <= divisor;
         count_ff   <= '0;
         busy_ff    <= 1'b1;
         done_ff    <= 1'b0;
      end else begin
         if (busy_ff) begin
            rem_ff   <= rem_in;
            quo_ff   <= quo_in;
            count_ff <= count_in;
         end
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

[src/fsvt_datapath.sv]
// ----------------------------------------------------------------------------
// fsvt_datapath: registers, coordinate mapping and frame store
// Holds the view registers, maps view coordinates to source coordinates,
// runs the resize divisions and owns the pixel memory.
// ----------------------------------------------------------------------------
module fsvt_datapath #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [fsvt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fsvt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_operation,
   input  logic [fsvt_pkg::COORD_W-1:0]      req_col,
   input  logic [fsvt_pkg::COORD_W-1:0]      req_row,
   input  logic [fsvt_pkg::CHAN_W-1:0]       req_red_in,
   input  logic [fsvt_pkg::CHAN_W-1:0]       req_green_in,
   input  logic [fsvt_pkg::CHAN_W-1:0]       req_blue_in,
   input  fsvt_pkg::fsvt_cmd_type            cmd,
   output fsvt_pkg::fsvt_status_type         status,
   output logic [fsvt_pkg::CHAN_W-1:0]       rsp_red_out,
   output logic [fsvt_pkg::CHAN_W-1:0]       rsp_green_out,
   output logic [fsvt_pkg::CHAN_W-1:0]       rsp_blue_out
);
   import fsvt_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [SIZE_W-1:0] WIDTH_CAP  =
      (MAX_WIDTH > 511) ? 9'd511 : SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] HEIGHT_CAP =
      (MAX_HEIGHT > 511) ? 9'd511 : SIZE_W'(MAX_HEIGHT);

   function automatic logic [SIZE_W-1:0] clamp_coord(input logic [COORD_W-1:0] c,
                                                      input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] ce;
      ce = {1'b0, c};
      return (ce >= s) ? s - SIZE_W'(1) : ce;
   endfunction

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] cap);
      if (v == '0) return SIZE_W'(1);
      if (v > cap) return cap;
      return v;
   endfunction

   // view registers
   logic [SIZE_W-1:0]  source_width_ff, source_height_ff;
   logic [MODE_W-1:0]  view_mode_ff;
   logic [COORD_W-1:0] crop_left_ff, crop_top_ff;
   logic [SIZE_W-1:0]  view_width_ff, view_height_ff;

   // item registers
   logic               op_ff;
   logic [COORD_W-1:0] col_ff, row_ff;
   logic [PIXEL_W-1:0] pix_ff;
   logic [SIZE_W-1:0]  src_col_ff, src_col_in;
   logic [SIZE_W-1:0]  src_row_ff, src_row_in;
   logic               zero_ff, zero_in;
   logic [PROD_W-1:0]  prod_col_ff, prod_col_in;
   logic [PROD_W-1:0]  prod_row_ff, prod_row_in;
   logic [PIXEL_W-1:0] rdata_ff;

   logic [PIXEL_W-1:0] mem [DEPTH];

   logic [SIZE_W-1:0]  sw, sh, tw, th;
   logic               crop_empty;
   logic [SIZE_W:0]    sum_w, sum_h;
   logic [SIZE_W-1:0]  crop_w, crop_h;
   logic [SIZE_W-1:0]  cc, rr;
   logic [PROD_W-1:0]  div_dividend;
   logic [SIZE_W-1:0]  div_divisor;
   logic [QUOT_W-1:0]  div_quotient;
   logic               div_done;
   logic [AW-1:0]      waddr, raddr;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= SIZE_RESET;
         source_height_ff <= SIZE_RESET;
         view_mode_ff     <= MODE_DIRECT;
         crop_left_ff     <= '0;
         crop_top_ff      <= '0;
         view_width_ff    <= SIZE_RESET;
         view_height_ff   <= SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_SOURCE_WIDTH:  source_width_ff  <= csr_wdata;
            REG_SOURCE_HEIGHT: source_height_ff <= csr_wdata;
            REG_VIEW_MODE:     view_mode_ff     <= csr_wdata[MODE_W-1:0];
            REG_CROP_LEFT:     crop_left_ff     <= csr_wdata[COORD_W-1:0];
            REG_CROP_TOP:      crop_top_ff      <= csr_wdata[COORD_W-1:0];
            REG_VIEW_WIDTH:    view_width_ff    <= csr_wdata;
            REG_VIEW_HEIGHT:   view_height_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      sw = clamp_size(source_width_ff, WIDTH_CAP);
      sh = clamp_size(source_height_ff, HEIGHT_CAP);
      tw = (view_width_ff == '0) ? SIZE_W'(1) : view_width_ff;
      th = (view_height_ff == '0) ? SIZE_W'(1) : view_height_ff;

      crop_empty = ({1'b0, crop_left_ff} >= sw) || ({1'b0, crop_top_ff} >= sh) ||
                   (view_width_ff == '0) || (view_height_ff == '0);
      sum_w  = {2'b00, crop_left_ff} + {1'b0, view_width_ff};
      sum_h  = {2'b00, crop_top_ff} + {1'b0, view_height_ff};
      crop_w = (sum_w > {1'b0, sw}) ? sw - {1'b0, crop_left_ff} : view_width_ff;
      crop_h = (sum_h > {1'b0, sh}) ? sh - {1'b0, crop_top_ff} : view_height_ff;

      cc = clamp_coord(col_ff, tw);
      rr = clamp_coord(row_ff, th);
      prod_col_in = PROD_W'(cc[COORD_W-1:0] * sw);
      prod_row_in = PROD_W'(rr[COORD_W-1:0] * sh);

      zero_in    = 1'b0;
      src_col_in = clamp_coord(col_ff, sw);
      src_row_in = clamp_coord(row_ff, sh);
      case (view_mode_ff)
         MODE_DIRECT: ;
         MODE_CROP: begin
            zero_in    = crop_empty;
            src_col_in = {1'b0, crop_left_ff} + clamp_coord(col_ff, crop_w);
            src_row_in = {1'b0, crop_top_ff} + clamp_coord(row_ff, crop_h);
         end
         MODE_ROTATE: begin
            src_col_in = clamp_coord(row_ff, sw);
            src_row_in = sh - SIZE_W'(1) - clamp_coord(col_ff, sh);
         end
         default: ;
      endcase
   end

   assign div_dividend = cmd.div_row ? prod_row_ff : prod_col_ff;
   assign div_divisor  = cmd.div_row ? th : tw;

   fsvt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_operation;
         col_ff <= req_col;
         row_ff <= req_row;
         pix_ff <= {req_red_in, req_green_in, req_blue_in};
      end
      if (cmd.latch_map) begin
         src_col_ff  <= src_col_in;
         src_row_ff  <= src_row_in;
         zero_ff     <= zero_in;
         prod_col_ff <= prod_col_in;
         prod_row_ff <= prod_row_in;
      end
      if (cmd.latch_div_col) begin
         src_col_ff <= div_quotient;
      end
      if (cmd.latch_div_row) begin
         src_row_ff <= div_quotient;
      end
   end

   assign waddr = AW'(32'(row_ff) * MAX_WIDTH + 32'(col_ff));
   assign raddr = AW'(32'(src_row_ff) * MAX_WIDTH + 32'(src_col_ff));

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         mem[waddr] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_comb begin
      status.is_read     = (op_ff == OP_READ);
      status.is_resize   = (view_mode_ff == MODE_RESIZE);
      status.wr_in_range = ({1'b0, col_ff} < sw) && ({1'b0, row_ff} < sh);
      status.div_done    = div_done;
   end

   assign rsp_red_out   = zero_ff ? '0 : rdata_ff[PIXEL_W-1:2*CHAN_W];
   assign rsp_green_out = zero_ff ? '0 : rdata_ff[2*CHAN_W-1:CHAN_W];
   assign rsp_blue_out  = zero_ff ? '0 : rdata_ff[CHAN_W-1:0];

endmodule

[src/fsvt_controller.sv]
// ----------------------------------------------------------------------------
// fsvt_controller: sequencer of the frame store view transform
// Steps one item through mapping, the two divisions of a resized read, the
// memory access and, for a read, the response cycle.
// ----------------------------------------------------------------------------
module fsvt_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   output logic                        rsp_valid,
   input  fsvt_pkg::fsvt_status_type   status,
   output fsvt_pkg::fsvt_cmd_type      cmd
);
   import fsvt_pkg::*;

   fsvt_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.latch_map = 1'b1;
            if (!status.is_read) begin
               cmd.mem_write = status.wr_in_range;
               state_in      = ST_IDLE;
            end else if (status.is_resize) begin
               state_in = ST_DIV_COL;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DIV_COL: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT_COL;
         end
         ST_WAIT_COL: begin
            if (status.div_done) begin
               cmd.latch_div_col = 1'b1;
               state_in          = ST_DIV_ROW;
            end
         end
         ST_DIV_ROW: begin
            cmd.div_start = 1'b1;
            cmd.div_row   = 1'b1;
            state_in      = ST_WAIT_ROW;
         end
         ST_WAIT_ROW: begin
            cmd.div_row = 1'b1;
            if (status.div_done) begin
               cmd.latch_div_row = 1'b1;
               state_in          = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[tb/frame_store_view_transform_unit_tb.sv]
// ----------------------------------------------------------------------------
// frame_store_view_transform_unit_tb: self-checking bench for the view unit
// Writes pixels and reads them back through direct, crop, rotate and resize
// views. A table of directed steps comes first, then random phases, each with
// a fresh view setting. Every read response is checked channel by channel
// against a fixed value or a predictor with its own copy of frame and views.
// ----------------------------------------------------------------------------
module frame_store_view_transform_unit_tb;

   import fsvt_pkg::*;

   localparam int FRAME_W       = 256;
   localparam int FRAME_H       = 256;
   localparam int RANDOM_ITEMS  = 426;
   localparam int SETTLE_CYCLES = 32;
   localparam int CYCLE_LIMIT   = 400000;

   typedef enum logic {STEP_ITEM, STEP_REG} step_kind_type;

   typedef struct packed {
      step_kind_type               kind;
      logic                        op;
      logic [COORD_W-1:0]          col;
      logic [COORD_W-1:0]          row;
      logic [PIXEL_W-1:0]          pix;
      logic                        typed;
      logic [PIXEL_W-1:0]          typed_pix;
      logic [CSR_INDEX_W-1:0]      index;
      logic [CSR_DATA_W-1:0]       value;
   } plan_step_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_operation = OP_WRITE;
   logic [COORD_W-1:0]      req_col = '0;
   logic [COORD_W-1:0]      req_row = '0;
   logic [CHAN_W-1:0]       req_red_in = '0;
   logic [CHAN_W-1:0]       req_green_in = '0;
   logic [CHAN_W-1:0]       req_blue_in = '0;
   logic                    rsp_valid;
   logic [CHAN_W-1:0]       rsp_red_out;
   logic [CHAN_W-1:0]       rsp_green_out;
   logic [CHAN_W-1:0]       rsp_blue_out;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // predictor copy of frame and view registers
   logic [PIXEL_W-1:0]      pixel_mem [0:FRAME_W*FRAME_H-1];
   bit                      pixel_written [0:FRAME_W*FRAME_H-1];
   logic [SIZE_W-1:0]       src_w_reg;
   logic [SIZE_W-1:0]       src_h_reg;
   logic [MODE_W-1:0]       mode_reg;
   logic [COORD_W-1:0]      crop_left_reg;
   logic [COORD_W-1:0]      crop_top_reg;
   logic [SIZE_W-1:0]       view_w_reg;
   logic [SIZE_W-1:0]       view_h_reg;

   logic [PIXEL_W-1:0]      expected_pixels [$];
   plan_step_type           directed_plan [$];

   int  fail_count    = 0;
   int  read_count    = 0;
   int  stored_count  = 0;
   int  dropped_count = 0;
   int  setting_count = 0;
   int  cycle_count   = 0;
   bit  steady_sender = 1'b0;

   frame_store_view_transform_unit #(
      .MAX_WIDTH  (FRAME_W),
      .MAX_HEIGHT (FRAME_H)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int size_limit(input int v, input int maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic int clip_coord(input int c, input int size);
      return (c >= size) ? size - 1 : c;
   endfunction

   function automatic void locate_source(input logic [COORD_W-1:0] col,
                                         input logic [COORD_W-1:0] row,
                                         output bit blank, output int src_col,
                                         output int src_row);
      int sw, sh, w, h, tw, th, c, r;
      sw = size_limit(src_w_reg, FRAME_W);
      sh = size_limit(src_h_reg, FRAME_H);
      blank = 1'b0;
      src_col = 0;
      src_row = 0;
      case (mode_reg)
         MODE_DIRECT: begin
            src_col = clip_coord(col, sw);
            src_row = clip_coord(row, sh);
         end
         MODE_CROP: begin
            if (crop_left_reg >= sw || crop_top_reg >= sh ||
                view_w_reg == 0 || view_h_reg == 0) begin
               blank = 1'b1;
            end else begin
               w = view_w_reg;
               if (crop_left_reg + w > sw) w = sw - crop_left_reg;
               h = view_h_reg;
               if (crop_top_reg + h > sh) h = sh - crop_top_reg;
               src_col = crop_left_reg + clip_coord(col, w);
               src_row = crop_top_reg + clip_coord(row, h);
            end
         end
         MODE_ROTATE: begin
            c = clip_coord(col, sh);
            r = clip_coord(row, sw);
            src_col = r;
            src_row = sh - 1 - c;
         end
         default: begin
            tw = (view_w_reg == 0) ? 1 : view_w_reg;
            th = (view_h_reg == 0) ? 1 : view_h_reg;
            c = clip_coord(col, tw);
            r = clip_coord(row, th);
            src_col = (c * sw) / tw;
            src_row = (r * sh) / th;
         end
      endcase
   endfunction

   function automatic logic [PIXEL_W-1:0] view_pixel(input logic [COORD_W-1:0] col,
                                                     input logic [COORD_W-1:0] row);
      bit blank;
      int sc, sr;
      locate_source(col, row, blank, sc, sr);
      return blank ? '0 : pixel_mem[sr * FRAME_W + sc];
   endfunction

   function automatic void record_write(input logic [COORD_W-1:0] col,
                                        input logic [COORD_W-1:0] row,
                                        input logic [PIXEL_W-1:0] pix);
      if (col < size_limit(src_w_reg, FRAME_W) && row < size_limit(src_h_reg, FRAME_H)) begin
         pixel_mem[row * FRAME_W + col] = pix;
         pixel_written[row * FRAME_W + col] = 1'b1;
         stored_count++;
      end else begin
         dropped_count++;
      end
   endfunction

   function automatic void check_channel(input string name, input logic [CHAN_W-1:0] want,
                                         input logic [CHAN_W-1:0] got);
      if (got !== want) begin
         $error("%s expected %02h got %02h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(negedge clock) begin
      logic [PIXEL_W-1:0] want;
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            $error("response with no read pending");
            fail_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_channel("red_out", want[23:16], rsp_red_out);
            check_channel("green_out", want[15:8], rsp_green_out);
            check_channel("blue_out", want[7:0], rsp_blue_out);
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         REG_SOURCE_WIDTH:  src_w_reg = value;
         REG_SOURCE_HEIGHT: src_h_reg = value;
         REG_VIEW_MODE:     mode_reg = value[MODE_W-1:0];
         REG_CROP_LEFT:     crop_left_reg = value[COORD_W-1:0];
         REG_CROP_TOP:      crop_top_reg = value[COORD_W-1:0];
         REG_VIEW_WIDTH:    view_w_reg = value;
         REG_VIEW_HEIGHT:   view_h_reg = value;
         default: ;
      endcase
   endtask

   // drain all reads, then hold off long enough for the last write to retire
   task automatic settle();
      start <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      setting_count++;
   endtask

   task automatic send_request(input logic op, input logic [COORD_W-1:0] col,
                               input logic [COORD_W-1:0] row,
                               input logic [PIXEL_W-1:0] pix, input bit typed,
                               input logic [PIXEL_W-1:0] typed_pix);
      int gap;
      gap = 0;
      if (!steady_sender && $urandom_range(99) < 11) gap = $urandom_range(1, 8);
      csr_we <= 1'b0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_col       <= col;
      req_row       <= row;
      req_red_in    <= pix[23:16];
      req_green_in  <= pix[15:8];
      req_blue_in   <= pix[7:0];
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      if (op == OP_WRITE) begin
         record_write(col, row, pix);
      end else begin
         expected_pixels.push_back(typed ? typed_pix : view_pixel(col, row));
         read_count++;
      end
   endtask

   // fill the source pixel first when the read would land on an unwritten entry
   task automatic read_random(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
      bit blank;
      int sc, sr;
      locate_source(col, row, blank, sc, sr);
      if (!blank && !pixel_written[sr * FRAME_W + sc])
         send_request(OP_WRITE, sc[7:0], sr[7:0], 24'($urandom), 1'b0, '0);
      send_request(OP_READ, col, row, 24'($urandom), 1'b0, '0);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_size();
      case ($urandom_range(9))
         0:       return 9'd0;
         1:       return 9'd1;
         2:       return 9'd256;
         3:       return 9'($urandom_range(257, 511));
         4, 5:    return 9'($urandom_range(1, 8));
         default: return 9'($urandom_range(2, 40));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_offset(input int limit);
      case ($urandom_range(7))
         0:       return 9'd0;
         1:       return 9'd255;
         2:       return 9'($urandom_range(255));
         default: return 9'($urandom_range(0, limit - 1));
      endcase
   endfunction

   task automatic pick_view(input int phase);
      write_reg(REG_SOURCE_WIDTH, pick_size());
      write_reg(REG_SOURCE_HEIGHT, pick_size());
      write_reg(REG_VIEW_MODE, 9'(phase % 4));
      write_reg(REG_CROP_LEFT, pick_offset(size_limit(src_w_reg, FRAME_W)));
      write_reg(REG_CROP_TOP, pick_offset(size_limit(src_h_reg, FRAME_H)));
      write_reg(REG_VIEW_WIDTH, pick_size());
      write_reg(REG_VIEW_HEIGHT, pick_size());
   endtask

   function automatic plan_step_type item_step(input logic op, input logic [7:0] col,
                                               input logic [7:0] row,
                                               input logic [23:0] pix, input bit typed);
      plan_step_type s;
      s = '0;
      s.kind = STEP_ITEM;
      s.op = op;
      s.col = col;
      s.row = row;
      s.pix = pix;
      s.typed = typed;
      s.typed_pix = pix;
      return s;
   endfunction

   function automatic plan_step_type reg_step(input logic [CSR_INDEX_W-1:0] index,
                                              input logic [CSR_DATA_W-1:0] value);
      plan_step_type s;
      s = '0;
      s.kind = STEP_REG;
      s.index = index;
      s.value = value;
      return s;
   endfunction

   initial begin
      int phase;
      int goal;
      int burst;
      int swe, she;
      logic [COORD_W-1:0] col, row;

      src_w_reg     = SIZE_RESET;
      src_h_reg     = SIZE_RESET;
      mode_reg      = MODE_DIRECT;
      crop_left_reg = '0;
      crop_top_reg  = '0;
      view_w_reg    = SIZE_RESET;
      view_h_reg    = SIZE_RESET;

      // corners and channel extremes at reset sizes
      directed_plan.push_back(item_step(OP_WRITE, 8'd0, 8'd0, 24'hAABBCC, 1'b0));
      directed_plan.push_back(item_step(OP_WRITE, 8'd255, 8'd255, 24'h112233, 1'b0));
      directed_plan.push_back(item_step(OP_WRITE, 8'd128, 8'd64, 24'hFFFFFF, 1'b0));
      directed_plan.push_back(item_step(OP_WRITE, 8'd1, 8'd1, 24'h000000, 1'b0));
      directed_plan.push_back(item_step(OP_READ, 8'd0, 8'd0, 24'hAABBCC, 1'b1));
      directed_plan.push_back(item_step(OP_READ, 8'd255, 8'd255, 24'h112233, 1'b1));
      directed_plan.push_back(item_step(OP_READ, 8'd128, 8'd64, 24'hFFFFFF, 1'b1));
      directed_plan.push_back(item_step(OP_READ, 8'd1, 8'd1, 24'h000000, 1'b1));
      // zero source size acts as one: write dropped, read clamps to origin
      directed_plan.push_back(reg_step(REG_SOURCE_WIDTH, 9'd0));
      directed_plan.push_back(reg_step(REG_SOURCE_HEIGHT, 9'd0));
      directed_plan.push_back(item_step(OP_WRITE, 8'd255, 8'd255, 24'h123456, 1'b0));
      directed_plan.push_back(item_step(OP_READ, 8'd200, 8'd200, 24'hAABBCC, 1'b1));
      // oversized source acts as the maximum
      directed_plan.push_back(reg_step(REG_SOURCE_WIDTH, 9'd511));
      directed_plan.push_back(reg_step(REG_SOURCE_HEIGHT, 9'd300));
      directed_plan.push_back(item_step(OP_READ, 8'd255, 8'd255, 24'h112233, 1'b1));
      directed_plan.push_back(reg_step(REG_SOURCE_WIDTH, 9'd16));
      directed_plan.push_back(reg_step(REG_SOURCE_HEIGHT, 9'd8));
      directed_plan.push_back(item_step(OP_WRITE, 8'd15, 8'd7, 24'h445566, 1'b0));
      directed_plan.push_back(item_step(OP_WRITE, 8'd0, 8'd7, 24'h778899, 1'b0));
      directed_plan.push_back(item_step(OP_WRITE, 8'd15, 8'd0, 24'h010203, 1'b0));
      directed_plan.push_back(item_step(OP_WRITE, 8'd16, 8'd0, 24'hFEDCBA, 1'b0));
      directed_plan.push_back(item_step(OP_READ, 8'd255, 8'd255, 24'h445566, 1'b1));
      directed_plan.push_back(reg_step(REG_VIEW_MODE, CSR_DATA_W'(MODE_ROTATE)));
      directed_plan.push_back(item_step(OP_READ, 8'd0, 8'd0, '0, 1'b0));
      directed_plan.push_back(item_step(OP_READ, 8'd255, 8'd255, '0, 1'b0));
      // empty crop windows read as zero
      directed_plan.push_back(reg_step(REG_VIEW_MODE, CSR_DATA_W'(MODE_CROP)));
      directed_plan.push_back(reg_step(REG_CROP_LEFT, 9'd16));
      directed_plan.push_back(item_step(OP_READ, 8'd0, 8'd0, 24'h000000, 1'b1));
      directed_plan.push_back(reg_step(REG_CROP_LEFT, 9'd15));
      directed_plan.push_back(reg_step(REG_CROP_TOP, 9'd7));
      directed_plan.push_back(reg_step(REG_VIEW_WIDTH, 9'd4));
      directed_plan.push_back(reg_step(REG_VIEW_HEIGHT, 9'd4));
      directed_plan.push_back(item_step(OP_READ, 8'd3, 8'd200, '0, 1'b0));
      directed_plan.push_back(reg_step(REG_VIEW_WIDTH, 9'd0));
      directed_plan.push_back(item_step(OP_READ, 8'd0, 8'd0, 24'h000000, 1'b1));
      // resize with zero target, then normal and oversized targets
      directed_plan.push_back(reg_step(REG_VIEW_MODE, CSR_DATA_W'(MODE_RESIZE)));
      directed_plan.push_back(reg_step(REG_VIEW_HEIGHT, 9'd0));
      directed_plan.push_back(item_step(OP_READ, 8'd255, 8'd255, 24'hAABBCC, 1'b1));
      directed_plan.push_back(reg_step(REG_VIEW_WIDTH, 9'd32));
      directed_plan.push_back(reg_step(REG_VIEW_HEIGHT, 9'd16));
      directed_plan.push_back(item_step(OP_READ, 8'd255, 8'd255, '0, 1'b0));
      directed_plan.push_back(reg_step(REG_VIEW_WIDTH, 9'd511));
      directed_plan.push_back(reg_step(REG_VIEW_HEIGHT, 9'd256));
      directed_plan.push_back(item_step(OP_READ, 8'd0, 8'd0, '0, 1'b0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == STEP_REG) begin
            if (i > 0 && directed_plan[i-1].kind == STEP_ITEM) settle();
            write_reg(directed_plan[i].index, directed_plan[i].value);
         end else begin
            send_request(directed_plan[i].op, directed_plan[i].col, directed_plan[i].row,
                         directed_plan[i].pix, directed_plan[i].typed,
                         directed_plan[i].typed_pix);
         end
      end

      goal  = read_count + stored_count + dropped_count + RANDOM_ITEMS;
      phase = 0;
      while (read_count + stored_count + dropped_count < goal) begin
         settle();
         pick_view(phase);
         steady_sender = (phase == 2 || phase == 3);
         burst = $urandom_range(30, 60);
         for (int k = 0; k < burst && read_count + stored_count + dropped_count < goal;
              k++) begin
            swe = size_limit(src_w_reg, FRAME_W);
            she = size_limit(src_h_reg, FRAME_H);
            if ($urandom_range(1) == 0) begin
               if ($urandom_range(99) < 15) begin
                  col = 8'($urandom_range(255));
                  row = 8'($urandom_range(255));
               end else begin
                  col = 8'($urandom_range(0, swe - 1));
                  row = 8'($urandom_range(0, she - 1));
               end
               send_request(OP_WRITE, col, row, 24'($urandom), 1'b0, '0);
            end else begin
               col = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
                                                8'($urandom_range(0, 40));
               row = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
                                                8'($urandom_range(0, 40));
               read_random(col, row);
            end
         end
         phase++;
      end
      steady_sender = 1'b0;

      start <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("checked %0d reads, stored %0d pixels, dropped %0d writes",
               read_count, stored_count, dropped_count);
      $display("views covered: %0d settings across direct, crop, rotate and resize",
               setting_count);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
